// ===== src/pwm_to_dac_drive_and_steer_top_defines.svh =====
// Assertion macros used by the checker of the drive and steer block.
`ifndef PWM_TO_DAC_DRIVE_AND_STEER_TOP_DEFINES_SVH
`define PWM_TO_DAC_DRIVE_AND_STEER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PTD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ptd_pkg.sv =====
// Package with the types, constants and codes of the drive and steer block.
package ptd_pkg;

  // Port widths.
  localparam int S_TDATA_W   = 128;
  localparam int M_TDATA_W   = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  // Field widths.
  localparam int PULSE_W = 16;
  localparam int MV_W    = 13;
  localparam int MODE_W  = 3;
  localparam int CODE_W  = 16;
  localparam int ANGLE_W = 15;

  // Shared divider widths: dividend, divisor and quotient.
  localparam int DIV_NUM_W = 44;
  localparam int DIV_DEN_W = 26;
  localparam int QUOT_W    = 16;

  // Scaling constants.
  localparam logic [14:0]     CODE_SCALE  = 15'd13107;
  localparam logic [9:0]      MV_PER_VOLT = 10'd1000;
  localparam logic [13:0]     STEER_FULL  = 14'd14500;
  localparam logic [MV_W-1:0] VOLT_CAP    = 13'd5000;

  // Register indexes on the configuration channel.
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_MV   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_MV   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RUN_MODE = 2'd2;

  // Register reset values.
  localparam logic [MV_W-1:0]   MIN_MV_RESET   = 13'd200;
  localparam logic [MV_W-1:0]   MAX_MV_RESET   = 13'd4200;

  // Run modes.
  localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MANUAL   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AUTO     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BRAKE    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OUTBRAKE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_STOP     = 3'd5;

  // Relay patterns: bit 0 forward, bit 1 reverse, bit 2 enable.
  localparam logic [2:0] RELAY_OFF     = 3'b000;
  localparam logic [2:0] RELAY_FORWARD = 3'b101;
  localparam logic [2:0] RELAY_REVERSE = 3'b110;

  typedef enum logic [1:0] {
    HEAD_STOP    = 2'd0,
    HEAD_FORWARD = 2'd1,
    HEAD_REVERSE = 2'd2
  } heading_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TMUL,
    ST_TSUM,
    ST_TSCALE,
    ST_TDIV,
    ST_TWAIT,
    ST_SMUL,
    ST_SDIV,
    ST_SWAIT,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath, at most one step per cycle.
  typedef struct packed {
    logic load;
    logic t_mul;
    logic t_sum;
    logic t_scale;
    logic div_start;
    logic t_save;
    logic s_mul;
    logic s_save;
    logic out_save;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

// ===== src/ptd_divider.sv =====
// Restoring divider, one quotient bit a cycle, saturating at the all-ones quotient.
module ptd_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ptd_pkg::DIV_NUM_W-1:0]  dividend,
  input  logic [ptd_pkg::DIV_DEN_W-1:0]  divisor,
  output logic                           done,
  output logic [ptd_pkg::QUOT_W-1:0]     quotient
);
  import ptd_pkg::*;

  localparam int HI_W  = DIV_NUM_W - QUOT_W;
  localparam int CNT_W = $clog2(QUOT_W + 1);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(QUOT_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [QUOT_W-1:0]    quo;

  logic [HI_W-1:0]      hi;
  logic                 overflow;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  // The quotient overflows when the upper part of the dividend reaches the divisor.
  assign hi       = dividend[DIV_NUM_W-1:QUOT_W];
  assign overflow = hi >= HI_W'(divisor);

  // One trial subtraction per step.
  assign trial = {rem, quo[QUOT_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= overflow ? '0 : DIV_STEPS;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Remainder and shifting quotient; the low dividend bits shift out as quotient bits enter.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= hi[DIV_DEN_W-1:0];
      quo <= overflow ? '1 : dividend[QUOT_W-1:0];
    end else if (busy && cnt != '0) begin
      rem <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo <= {quo[QUOT_W-2:0], fits};
    end
  end

  assign done     = busy && (cnt == '0);
  assign quotient = quo;

endmodule

// ===== src/ptd_datapath.sv =====
// Datapath: configuration registers, operand set-up, multipliers, divider and result word.
module ptd_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  ptd_pkg::cmd_t                    cmd,
  output ptd_pkg::status_t                 status,
  input  logic [ptd_pkg::S_TDATA_W-1:0]    in_data,
  output logic [ptd_pkg::M_TDATA_W-1:0]    out_data,
  input  logic                             cfg_we,
  input  logic [ptd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ptd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ptd_pkg::*;

  // Configuration registers.
  logic [MV_W-1:0]   min_mv;
  logic [MV_W-1:0]   max_mv;
  logic [MODE_W-1:0] run_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_mv   <= MIN_MV_RESET;
      max_mv   <= MAX_MV_RESET;
      run_mode <= MODE_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_MV:   min_mv   <= cfg_data[MV_W-1:0];
        REG_MAX_MV:   max_mv   <= cfg_data[MV_W-1:0];
        REG_RUN_MODE: run_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [PULSE_W-1:0] tp, tt, ttop, tbot, sp, st, stop_w, sbot;
  assign tp     = in_data[0*PULSE_W +: PULSE_W];
  assign tt     = in_data[1*PULSE_W +: PULSE_W];
  assign ttop   = in_data[2*PULSE_W +: PULSE_W];
  assign tbot   = in_data[3*PULSE_W +: PULSE_W];
  assign sp     = in_data[4*PULSE_W +: PULSE_W];
  assign st     = in_data[5*PULSE_W +: PULSE_W];
  assign stop_w = in_data[6*PULSE_W +: PULSE_W];
  assign sbot   = in_data[7*PULSE_W +: PULSE_W];

  // Offsets from trim and the signed span they are measured against.
  logic               t_above, s_above;
  logic [PULSE_W-1:0] t_num_c, s_num_c, t_abs_c, s_abs_c;
  logic [PULSE_W:0]   t_den_c, s_den_c;
  logic [MV_W-1:0]    vmax_c;
  heading_t           heading_c;

  always_comb begin
    t_above = tp > tt;
    t_num_c = t_above ? tp - tt : tt - tp;
    t_den_c = t_above ? {1'b0, ttop} - {1'b0, tt} : {1'b0, tt} - {1'b0, tbot};
    t_abs_c = t_den_c[PULSE_W] ? PULSE_W'(-t_den_c) : t_den_c[PULSE_W-1:0];

    s_above = sp > st;
    s_num_c = s_above ? sp - st : st - sp;
    s_den_c = s_above ? {1'b0, stop_w} - {1'b0, st} : {1'b0, st} - {1'b0, sbot};
    s_abs_c = s_den_c[PULSE_W] ? PULSE_W'(-s_den_c) : s_den_c[PULSE_W-1:0];

    if (tp == tt) begin
      heading_c = HEAD_STOP;
    end else if (t_above) begin
      heading_c = HEAD_FORWARD;
    end else begin
      heading_c = HEAD_REVERSE;
    end

    // Effective top voltage: never below the minimum, capped otherwise.
    if (max_mv <= min_mv) begin
      vmax_c = min_mv;
    end else if (max_mv > VOLT_CAP) begin
      vmax_c = VOLT_CAP;
    end else begin
      vmax_c = max_mv;
    end
  end

  // Operands captured when a word is taken.
  logic [PULSE_W-1:0] t_num, t_abs, s_num, s_abs;
  logic               t_neg, t_zero, s_neg, s_zero, s_cw, s_eq;
  heading_t           heading_r;
  logic [MV_W-1:0]    vmin, vmax;
  logic signed [MV_W:0] dv;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_num     <= t_num_c;
      t_abs     <= t_abs_c;
      t_neg     <= t_den_c[PULSE_W];
      t_zero    <= t_den_c == '0;
      s_num     <= s_num_c;
      s_abs     <= s_abs_c;
      s_neg     <= s_den_c[PULSE_W];
      s_zero    <= s_den_c == '0;
      s_cw      <= s_above;
      s_eq      <= sp == st;
      heading_r <= heading_c;
      vmin      <= min_mv;
      vmax      <= vmax_c;
      dv        <= $signed({1'b0, vmax_c}) - $signed({1'b0, min_mv});
    end
  end

  // Throttle numerator over |span|: vmin*|span| + sign*offset*(vmax-vmin).
  logic [MV_W+PULSE_W-1:0]          prod_a;
  logic signed [MV_W+PULSE_W+1:0]   prod_b;
  logic signed [MV_W+PULSE_W+1:0]   b_term;
  logic signed [31:0]               n_c;
  logic signed [31:0]               n_val;
  logic [PULSE_W-1:0]               a_eff;

  always_ff @(posedge clk) begin
    if (cmd.t_mul) begin
      prod_a <= vmin * t_abs;
      prod_b <= $signed({1'b0, t_num}) * dv;
    end
  end

  assign b_term = t_neg ? -prod_b : prod_b;
  assign n_c    = $signed({3'b000, prod_a}) + $signed({b_term[MV_W+PULSE_W+1], b_term});

  // A zero span means full throttle: the code then comes from vmax over one.
  always_ff @(posedge clk) begin
    if (cmd.t_sum) begin
      if (t_zero) begin
        n_val <= $signed({19'd0, vmax});
        a_eff <= PULSE_W'(1);
      end else begin
        n_val <= n_c;
        a_eff <= t_abs;
      end
    end
  end

  // Divider operands, loaded for the throttle code and then for the steering angle.
  logic [45:0]           scale_prod;
  logic [DIV_DEN_W-1:0]  den_scaled;
  logic [29:0]           steer_prod;
  logic [DIV_NUM_W-1:0]  div_num;
  logic [DIV_DEN_W-1:0]  div_den;

  assign scale_prod = CODE_SCALE * n_val[30:0];
  assign den_scaled = MV_PER_VOLT * a_eff;
  assign steer_prod = STEER_FULL * s_num;

  always_ff @(posedge clk) begin
    if (cmd.t_scale) begin
      div_num <= scale_prod[DIV_NUM_W-1:0];
      div_den <= den_scaled;
    end else if (cmd.s_mul) begin
      if (s_zero) begin
        div_num <= DIV_NUM_W'(STEER_FULL);
        div_den <= DIV_DEN_W'(1);
      end else begin
        div_num <= DIV_NUM_W'(steer_prod);
        div_den <= DIV_DEN_W'(s_abs);
      end
    end
  end

  logic [QUOT_W-1:0] quotient;

  ptd_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (status.div_done),
    .quotient (quotient)
  );

  // Throttle code: zero at trim or when the numerator goes negative.
  logic [CODE_W-1:0] code_r;

  always_ff @(posedge clk) begin
    if (cmd.t_save) begin
      code_r <= (heading_r == HEAD_STOP || n_val[31]) ? '0 : quotient;
    end
  end

  // Steering angle: clamp the magnitude, then apply span sign and direction.
  logic [13:0]              mag;
  logic [ANGLE_W-1:0]       angle_c;
  logic [ANGLE_W-1:0]       angle_r;

  always_comb begin
    mag = (quotient > QUOT_W'(STEER_FULL)) ? STEER_FULL : quotient[13:0];
    if (s_eq) begin
      angle_c = '0;
    end else if (s_neg ^ s_cw) begin
      angle_c = -{1'b0, mag};
    end else begin
      angle_c = {1'b0, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.s_save) begin
      angle_r <= angle_c;
    end
  end

  // Relay state follows the run mode when a result is published.
  logic [2:0] relay_bits;
  logic [2:0] relay_next;

  always_comb begin
    relay_next = relay_bits;
    case (run_mode)
      MODE_NONE, MODE_STOP: relay_next = RELAY_OFF;
      MODE_MANUAL, MODE_AUTO: begin
        case (heading_r)
          HEAD_FORWARD: relay_next = RELAY_FORWARD;
          HEAD_REVERSE: relay_next = RELAY_REVERSE;
          default:      relay_next = RELAY_OFF;
        endcase
      end
      MODE_BRAKE, MODE_OUTBRAKE: relay_next = relay_bits;
      default: relay_next = relay_bits;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_bits <= RELAY_OFF;
    end else if (cmd.out_save) begin
      relay_bits <= relay_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_save) begin
      out_data <= {4'b0000, relay_next, heading_r, angle_r, 8'h00, code_r, code_r};
    end
  end

endmodule

// ===== src/ptd_ctrl.sv =====
// Controller: sequences one word through the datapath and owns both handshakes.
module ptd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ptd_pkg::status_t  status,
  output ptd_pkg::cmd_t     cmd
);
  import ptd_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_TMUL;
        end
      end
      ST_TMUL: begin
        cmd.t_mul  = 1'b1;
        state_next = ST_TSUM;
      end
      ST_TSUM: begin
        cmd.t_sum  = 1'b1;
        state_next = ST_TSCALE;
      end
      ST_TSCALE: begin
        cmd.t_scale = 1'b1;
        state_next  = ST_TDIV;
      end
      ST_TDIV: begin
        cmd.div_start = 1'b1;
        state_next    = ST_TWAIT;
      end
      ST_TWAIT: begin
        if (status.div_done) begin
          cmd.t_save = 1'b1;
          state_next = ST_SMUL;
        end
      end
      ST_SMUL: begin
        cmd.s_mul  = 1'b1;
        state_next = ST_SDIV;
      end
      ST_SDIV: begin
        cmd.div_start = 1'b1;
        state_next    = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (status.div_done) begin
          cmd.s_save = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Publish once the output register is free or being emptied.
        if (!out_valid || out_ready) begin
          cmd.out_save = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output word valid.
  always_comb begin
    if (cmd.out_save) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== src/pwm_to_dac_drive_and_steer_top.sv =====
// Top level of the throttle-to-DAC and steering drive block.
//
// Input stream (s_*): one word holds a throttle and a steering PWM sample, each
// with pulse, trim, top and bottom widths. Output stream (m_*): one word per
// input word with the DAC code, the 24-bit DAC frame, the signed steering
// angle, the heading and the three relay drives after this word.
// Configuration channel (cfg_*): min and max millivolts and the run mode, always
// ready; write only while no word is in flight.
// Each word runs two 16-step divisions on one shared restoring divider: the
// throttle division after the load, multiply, sum and scale steps, the steering
// division after a multiply step; a new word is taken once the last is published.
// A division whose quotient saturates ends in the cycle after its start, so a
// word with a saturated code or angle finishes sooner.
// s_tready is high only while the controller waits for a word; a finished word
// sits in the output register, so a new word is taken while it waits.
// If the receiver stalls, the next result waits in its last step until the
// output register is emptied; m_tdata holds steady while a word waits on m_tready.
// Reset: output empty, relays off, registers at 200 mV, 4200 mV and mode none.
module pwm_to_dac_drive_and_steer_top (
  input  logic                             clk,
  input  logic                             rst,
  // throttle_pulse, throttle_trim, throttle_top, throttle_bottom,
  // steer_pulse, steer_trim, steer_top, steer_bottom (16 bits each)
  input  logic [ptd_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // dac_code[15:0], dac_frame[39:16], steer_angle[54:40], heading[56:55],
  // relay_forward[57], relay_reverse[58], relay_enable[59], zero fill[63:60]
  output logic [ptd_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ptd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ptd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ptd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Registers accept a write in any cycle.
  assign cfg_ready = 1'b1;

  ptd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ptd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .out_data  (m_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== src/ptd_checker.sv =====
// Port-level checker for the drive and steer block, bound to its top level.
`include "pwm_to_dac_drive_and_steer_top_defines.svh"

module ptd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [63:0] m_tdata,
  input logic        m_tvalid,
  input logic        m_tready
);

  // A stalled result word stays put.
  `PTD_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

  // One word at a time: the input closes right after a word is taken.
  `PTD_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready, "input still open after a word was taken")

  // The frame carries the code under eight zero bits, and the fill is zero.
  `PTD_ASSERT_NOW(a_frame_code, clk, rst, m_tvalid, (m_tdata[31:16] == m_tdata[15:0]) && (m_tdata[39:32] == 8'h00) && (m_tdata[63:60] == 4'h0), "frame does not match code")

  // Relays: never both directions, and enable exactly when a direction is on.
  `PTD_ASSERT_NOW(a_relay_pattern, clk, rst, m_tvalid, !(m_tdata[57] && m_tdata[58]) && ((m_tdata[57] || m_tdata[58]) == m_tdata[59]), "illegal relay pattern")

  // Steering angle stays within full scale.
  `PTD_ASSERT_NOW(a_angle_range, clk, rst, m_tvalid, ($signed(m_tdata[54:40]) <= 15'sd14500) && ($signed(m_tdata[54:40]) >= -15'sd14500), "steering angle out of range")

endmodule

bind pwm_to_dac_drive_and_steer_top ptd_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the throttle-to-DAC and steering drive block.
`timescale 1ns / 1ps

module tb;
  import ptd_pkg::*;

  localparam int     LIMIT_CYCLES = 400000;
  localparam int     SETTLE_CYCLES = 60;
  localparam int     RANDOM_PER_SETTING = 60;
  localparam int     SETTINGS_COUNT = 10;
  localparam longint CODE_MULT = longint'(CODE_SCALE);
  localparam longint MV_DIV = longint'(MV_PER_VOLT);
  localparam longint ANGLE_SPAN = longint'(STEER_FULL);
  localparam longint MV_CAP = longint'(VOLT_CAP);

  // Run mode codes with no meaning of their own; they hold the relays.
  localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

  // One PWM channel: pulse in the lowest bits, then trim, top and bottom.
  typedef struct packed {
    logic [PULSE_W-1:0] bottom;
    logic [PULSE_W-1:0] top;
    logic [PULSE_W-1:0] trim;
    logic [PULSE_W-1:0] pulse;
  } pwm_chan_t;

  // Throttle channel in the low half of the input word, steering above it.
  typedef struct packed {
    pwm_chan_t steer;
    pwm_chan_t throttle;
  } pwm_sample_t;

  typedef struct {
    logic [CODE_W-1:0]  code;
    logic [23:0]        frame;
    logic [ANGLE_W-1:0] angle;
    heading_t           heading;
    logic [2:0]         relays;
  } drive_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Copy of the block's registers and relay state.
  logic [MV_W-1:0]   mv_floor = MIN_MV_RESET;
  logic [MV_W-1:0]   mv_ceiling = MAX_MV_RESET;
  logic [MODE_W-1:0] mode_now = MODE_NONE;
  logic [2:0]        relay_latch = RELAY_OFF;

  pwm_sample_t   sample_q[$];
  drive_result_t result_q[$];

  int cycle_count = 0;
  int mismatch_count = 0;
  int words_checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int gap_left = 0;
  int stall_left = 0;

  pwm_to_dac_drive_and_steer_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Exact floor of the scaled drive voltage, saturated to the code range.
  function automatic logic [CODE_W-1:0] dac_level(longint num, longint den, longint vlo,
                                                  longint vhi);
    longint n;
    longint d;
    longint q;
    if (den == 0) begin
      n = CODE_MULT * vhi;
      d = MV_DIV;
    end else begin
      n = CODE_MULT * (vlo * den + num * (vhi - vlo));
      d = MV_DIV * den;
      if (d < 0) begin
        n = -n;
        d = -d;
      end
    end
    if (n < 0) return '0;
    q = n / d;
    if (q > 65535) q = 65535;
    return q[CODE_W-1:0];
  endfunction

  // Proportional steering share, truncated toward zero and saturated.
  function automatic longint steer_share(longint num, longint den);
    longint q;
    if (den == 0) return ANGLE_SPAN;
    if (den > 0) q = (num * ANGLE_SPAN) / den;
    else q = -((num * ANGLE_SPAN) / (-den));
    if (q > ANGLE_SPAN) q = ANGLE_SPAN;
    if (q < -ANGLE_SPAN) q = -ANGLE_SPAN;
    return q;
  endfunction

  // Works out the result word for one sample and advances the relay state.
  function automatic drive_result_t compute_drive(pwm_sample_t s);
    drive_result_t r;
    longint vlo;
    longint vhi;
    longint tp;
    longint tt;
    longint sp;
    longint st;
    longint ang;
    vlo = longint'(mv_floor);
    vhi = longint'(mv_ceiling);
    if (vhi <= vlo) vhi = vlo;
    else if (vhi > MV_CAP) vhi = MV_CAP;
    tp = longint'(s.throttle.pulse);
    tt = longint'(s.throttle.trim);
    sp = longint'(s.steer.pulse);
    st = longint'(s.steer.trim);
    r.code = '0;
    if (tp == tt) begin
      r.heading = HEAD_STOP;
    end else if (tp > tt) begin
      r.heading = HEAD_FORWARD;
      r.code = dac_level(tp - tt, longint'(s.throttle.top) - tt, vlo, vhi);
    end else begin
      r.heading = HEAD_REVERSE;
      r.code = dac_level(tt - tp, tt - longint'(s.throttle.bottom), vlo, vhi);
    end
    r.frame = {8'h00, r.code};
    ang = 0;
    if (sp > st) ang = -steer_share(sp - st, longint'(s.steer.top) - st);
    else if (sp < st) ang = steer_share(st - sp, st - longint'(s.steer.bottom));
    r.angle = ang[ANGLE_W-1:0];
    // Relays clear, follow the heading, or hold, depending on the run mode.
    case (mode_now)
      MODE_NONE, MODE_STOP: relay_latch = RELAY_OFF;
      MODE_MANUAL, MODE_AUTO: begin
        if (r.heading == HEAD_FORWARD) relay_latch = RELAY_FORWARD;
        else if (r.heading == HEAD_REVERSE) relay_latch = RELAY_REVERSE;
        else relay_latch = RELAY_OFF;
      end
      default: relay_latch = relay_latch;
    endcase
    r.relays = relay_latch;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("%0t: word %0d, %s: got %0d, expected %0d", $realtime, words_checked, what,
             got, want);
  endtask

  task automatic check_field(string what, longint got, longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Register model follows every write accepted on the configuration channel.
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_MV: mv_floor <= cfg_data;
        REG_MAX_MV: mv_ceiling <= cfg_data;
        REG_RUN_MODE: mode_now <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sender: presents queued samples, holds a word until taken, idles in bursts.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
      relay_latch = RELAY_OFF;
    end else begin
      if (s_tvalid && s_tready) result_q.push_back(compute_drive(sample_q.pop_front()));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (sample_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if ($urandom_range(0, 99) < send_idle_pct) begin
          gap_left = $urandom_range(0, 12);
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata <= sample_q[0];
        end
      end
    end
  end

  // Receiver: checks each accepted word against the oldest prediction.
  always @(posedge clk) begin
    drive_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("word with nothing outstanding", longint'(m_tdata[CODE_W-1:0]), 0);
        end else begin
          want = result_q.pop_front();
          check_field("dac_code", longint'(m_tdata[15:0]), longint'(want.code));
          check_field("dac_frame", longint'(m_tdata[39:16]), longint'(want.frame));
          check_field("steer_angle", longint'($signed(m_tdata[54:40])),
                      longint'($signed(want.angle)));
          check_field("heading", longint'(m_tdata[56:55]), longint'(want.heading));
          check_field("relay_forward", longint'(m_tdata[57]), longint'(want.relays[0]));
          check_field("relay_reverse", longint'(m_tdata[58]), longint'(want.relays[1]));
          check_field("relay_enable", longint'(m_tdata[59]), longint'(want.relays[2]));
          check_field("zero fill", longint'(m_tdata[63:60]), 0);
        end
        words_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
        stall_left = $urandom_range(0, 12);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             result_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic pwm_chan_t chan(int p, int t, int hi, int lo);
    pwm_chan_t c;
    c.pulse = PULSE_W'(p);
    c.trim = PULSE_W'(t);
    c.top = PULSE_W'(hi);
    c.bottom = PULSE_W'(lo);
    return c;
  endfunction

  // Servo-like or wide valid limits with random pulses, some broken limits, some noise.
  function automatic pwm_chan_t random_chan();
    pwm_chan_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      c.trim = PULSE_W'($urandom_range(1200, 1800));
      c.bottom = PULSE_W'(c.trim - $urandom_range(1, 700));
      c.top = PULSE_W'(c.trim + $urandom_range(1, 700));
    end else if (pick < 70) begin
      c.trim = PULSE_W'($urandom_range(1, 65534));
      c.bottom = PULSE_W'($urandom_range(0, c.trim - 1));
      c.top = PULSE_W'($urandom_range(c.trim + 1, 65535));
    end else if (pick < 85) begin
      c.trim = PULSE_W'($urandom_range(1000, 2000));
      c.top = ($urandom_range(0, 2) == 0) ? c.trim : 16'($urandom_range(500, 2500));
      c.bottom = ($urandom_range(0, 2) == 0) ? c.trim : 16'($urandom_range(500, 2500));
    end else begin
      c = {$urandom, $urandom};
    end
    if (pick < 85) begin
      case ($urandom_range(0, 9))
        0: c.pulse = c.trim;
        1: c.pulse = c.top;
        2: c.pulse = c.bottom;
        3: c.pulse = PULSE_W'($urandom_range(0, 65535));
        default: begin
          if (c.top >= c.bottom) c.pulse = PULSE_W'($urandom_range(c.bottom, c.top));
          else c.pulse = PULSE_W'($urandom_range(c.top, c.bottom));
        end
      endcase
    end
    return c;
  endfunction

  task automatic wait_idle();
    while (sample_q.size() != 0 || result_q.size() != 0 || s_tvalid) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Register settings per phase: extremes, inverted limits, capped max, every mode but none.
  int set_min[SETTINGS_COUNT] = '{0, 0, 5000, 0, 5000, 1500, 200, 700, 300, 0};
  int set_max[SETTINGS_COUNT] = '{5000, 5000, 0, 0, 5000, 8191, 4200, 3300, 4600, 0};
  logic [MODE_W-1:0] set_mode[SETTINGS_COUNT] = '{MODE_MANUAL, MODE_BRAKE, MODE_AUTO,
      MODE_OUTBRAKE, MODE_MANUAL, MODE_UNUSED_6, MODE_STOP, MODE_AUTO, MODE_UNUSED_7,
      MODE_MANUAL};

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 30;
    recv_stall_pct = 30;

    // Directed samples at the reset register values.
    @(negedge clk);
    sample_q.push_back({chan(1500, 1500, 2000, 1000), chan(1500, 1500, 2000, 1000)});
    sample_q.push_back({chan(2000, 1500, 2000, 1000), chan(2000, 1500, 2000, 1000)});
    sample_q.push_back({chan(1000, 1500, 2000, 1000), chan(1000, 1500, 2000, 1000)});
    sample_q.push_back({chan(1250, 1500, 2000, 1000), chan(1750, 1500, 2000, 1000)});
    sample_q.push_back({chan(1501, 1500, 2000, 1000), chan(1501, 1500, 2000, 1000)});
    sample_q.push_back({chan(1499, 1501, 2000, 0), chan(1499, 1500, 2000, 1000)});
    // Top or bottom equal to trim: the fraction counts as one.
    sample_q.push_back({chan(1600, 1500, 1500, 1000), chan(1600, 1500, 1500, 1000)});
    sample_q.push_back({chan(1400, 1500, 2000, 1500), chan(1400, 1500, 2000, 1500)});
    // Limits on the wrong side of trim give a negative fraction.
    sample_q.push_back({chan(1600, 1500, 1000, 1000), chan(1600, 1500, 1000, 1000)});
    sample_q.push_back({chan(1000, 1500, 2000, 2000), chan(1000, 1500, 2000, 2000)});
    // Pulses far outside the limits saturate code and angle; extreme field values follow.
    sample_q.push_back({chan(65535, 1500, 2000, 1000), chan(65535, 1500, 2000, 1000)});
    sample_q.push_back({chan(0, 1500, 2000, 1000), chan(0, 1500, 2000, 1000)});
    sample_q.push_back({chan(0, 0, 0, 0), chan(0, 0, 0, 0)});
    sample_q.push_back({chan(65535, 65535, 65535, 65535), chan(65535, 65535, 65535, 65535)});
    sample_q.push_back({chan(0, 65535, 65535, 0), chan(65535, 0, 65535, 0)});
    sample_q.push_back({chan(65535, 0, 65535, 0), chan(0, 65535, 65535, 0)});
    sample_q.push_back({chan(0, 65535, 0, 65535), chan(1, 0, 65535, 0)});
    sample_q.push_back({chan(1, 0, 0, 0), chan(65534, 65535, 0, 65535)});
    wait_idle();

    // Random phases, each behind a fresh write of every register.
    for (int ph = 0; ph < SETTINGS_COUNT; ph++) begin
      write_reg(REG_MIN_MV, CFG_DATA_W'(set_min[ph]));
      write_reg(REG_MAX_MV, CFG_DATA_W'(set_max[ph]));
      write_reg(REG_RUN_MODE, CFG_DATA_W'(set_mode[ph]));
      if (ph == SETTINGS_COUNT - 1 || ph % 3 == 2) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct = $urandom_range(5, 50);
        recv_stall_pct = $urandom_range(5, 50);
      end
      @(negedge clk);
      for (int i = 0; i < RANDOM_PER_SETTING; i++)
        sample_q.push_back({random_chan(), random_chan()});
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d result words over %0d register settings plus reset values,",
             words_checked, SETTINGS_COUNT);
    $display("run modes 0 to 7, with %0d mismatches.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
